// ===== rtl/crfr_pkg.sv =====
package crfr_pkg;

  localparam int unsigned ParamCount   = 16;
  localparam int unsigned SpecialCount = 3;
  localparam int unsigned PayloadBytes = 8;
  localparam int unsigned WinLen       = PayloadBytes + 2;

  localparam logic [7:0] StartMark = 8'd7;
  localparam logic [7:0] StopMark  = 8'd8;

  // lowest special number, -3 as a 32-bit pattern
  localparam logic [31:0] SpecialLow = 32'hFFFF_FFFD;

  typedef enum logic [1:0] {
    ACT_PARAM   = 2'd0,
    ACT_SPECIAL = 2'd1,
    ACT_IGNORE  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    MODE_LIVE   = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_REC_TX = 2'd2,
    MODE_WAIT   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SPC_IDX0 = 2'd0,
    SPC_IDX1 = 2'd1,
    SPC_MODE = 2'd2
  } special_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic        fire;
    logic [31:0] num;
    logic [31:0] val;
  } frame_t;

endpackage

// ===== rtl/crfr_rx_if.sv =====
interface crfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/crfr_res_if.sv =====
interface crfr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  target_index;
  logic [31:0] word_value;
  logic [1:0]  send_mode;

  modport source (
    output valid, output action, output target_index, output word_value,
    output send_mode, input ready
  );
  modport sink (
    input valid, input action, input target_index, input word_value,
    input send_mode, output ready
  );
endinterface

// ===== rtl/command_frame_receiver_core.sv =====
// Command frame receiver: takes one received byte per transfer and watches the
// last ten bytes since the previous frame. A start byte 7 followed nine bytes
// later by a stop byte 8 forms a frame: bytes 1-4 are a signed little-endian
// parameter number, bytes 5-8 a 32-bit value. Each frame yields one result
// (parameter write, special write for -1..-3, or ignored) and restarts the
// window; numbers -1..-3 update the special store and -3 may switch the mode.
// A byte is taken every cycle; the byte window is a nine-cell shift chain plus
// the incoming byte, with a parallel start/stop compare, and one output
// register holds the result, so input stalls only while a result is held and
// not taken by the sink.
module command_frame_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  crfr_rx_if.sink     rx_i,
  crfr_res_if.source  res_o
);
  import crfr_pkg::*;

  logic [7:0] cell_byte  [WinLen-1];
  logic       cell_valid [WinLen-1];
  cell_ctrl_t ctrl;
  frame_t     frame;
  logic       xfer;

  assign rx_i.ready = ~res_o.valid | res_o.ready;
  assign xfer       = rx_i.valid & rx_i.ready;

  // cell 0 holds the newest byte; oldest held byte sits in cell WinLen-2
  always_comb begin
    frame.fire = xfer && cell_valid[WinLen-2] && cell_byte[WinLen-2] == StartMark
                 && rx_i.rx_byte == StopMark;
    frame.num  = {cell_byte[4], cell_byte[5], cell_byte[6], cell_byte[7]};
    frame.val  = {cell_byte[0], cell_byte[1], cell_byte[2], cell_byte[3]};
    ctrl.shift = xfer;
    ctrl.clear = frame.fire;
  end

  for (genvar k = 0; k < WinLen - 1; k++) begin : g_cell
    if (k == 0) begin : g_head
      crfr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .byte_i  (rx_i.rx_byte),
        .valid_i (1'b1),
        .byte_o  (cell_byte[k]),
        .valid_o (cell_valid[k])
      );
    end else begin : g_body
      crfr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .byte_i  (cell_byte[k-1]),
        .valid_i (cell_valid[k-1]),
        .byte_o  (cell_byte[k]),
        .valid_o (cell_valid[k])
      );
    end
  end

  crfr_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame),
    .res_o   (res_o)
  );
endmodule

// ===== rtl/crfr_cell.sv =====
module crfr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crfr_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic                valid_i,
  output logic [7:0]          byte_o,
  output logic                valid_o
);
  import crfr_pkg::*;

  logic [7:0] byte_q;
  logic       valid_q, valid_d;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift && !ctrl_i.clear) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;
endmodule

// ===== rtl/crfr_decode.sv =====
module crfr_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crfr_pkg::frame_t frame_i,
  crfr_res_if.source     res_o
);
  import crfr_pkg::*;

  logic [31:0] spc_q [SpecialCount];
  logic [1:0]  mode_q, mode_d;
  logic        out_valid_q;
  logic [1:0]  act_q;
  logic [3:0]  tgt_q;
  logic [31:0] val_q;
  logic [1:0]  smode_q;

  action_e     act;
  logic [3:0]  tgt;
  logic [1:0]  spc_idx;
  logic        is_spc;

  always_comb begin
    spc_idx = ~frame_i.num[1:0];
    is_spc  = 1'b0;
    mode_d  = mode_q;
    if (frame_i.num < 32'(ParamCount)) begin
      act = ACT_PARAM;
      tgt = frame_i.num[3:0];
    end else if (frame_i.num >= SpecialLow) begin
      act    = ACT_SPECIAL;
      tgt    = {2'b00, spc_idx};
      is_spc = 1'b1;
      // mode switches only on a changed value for the mode word
      if (spc_idx == SPC_MODE && frame_i.val != spc_q[SPC_MODE]) begin
        if (frame_i.val == 32'd1) begin
          mode_d = MODE_RECORD;
        end else if (frame_i.val == 32'd0) begin
          mode_d = MODE_REC_TX;
        end
      end
    end else begin
      act = ACT_IGNORE;
      tgt = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_LIVE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SpecialCount; i++) begin
        spc_q[i] <= '0;
      end
    end else begin
      if (frame_i.fire) begin
        mode_q <= mode_d;
        if (is_spc) begin
          spc_q[spc_idx] <= frame_i.val;
        end
      end
      out_valid_q <= frame_i.fire | (out_valid_q & ~res_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.fire) begin
      act_q   <= act;
      tgt_q   <= tgt;
      val_q   <= frame_i.val;
      smode_q <= mode_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.action       = act_q;
  assign res_o.target_index = tgt_q;
  assign res_o.word_value   = val_q;
  assign res_o.send_mode    = smode_q;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import crfr_pkg::*;

  typedef struct packed {
    action_e     action;
    logic [3:0]  target;
    logic [31:0] word;
    mode_e       mode;
  } frame_res_t;

  logic clk;
  logic rst_n;

  crfr_rx_if  rx_bus ();
  crfr_res_if res_bus ();

  command_frame_receiver_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_bus),
    .res_o  (res_bus)
  );

  // shadow of the deframer state
  logic [7:0]  win_q [WinLen];
  int unsigned win_fill;
  logic [31:0] spc_store [SpecialCount];
  mode_e       mode_q;

  frame_res_t frames_due [$];
  int fails;
  int bytes_sent;
  int frames_made;
  int frames_seen;
  int rx_gap_max;
  int res_gap_max;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  function automatic void deframe_byte(input logic [7:0] b);
    frame_res_t  r;
    logic [31:0] num;
    logic [31:0] val;
    if (win_fill >= WinLen) begin
      for (int k = 0; k < WinLen - 1; k++) win_q[k] = win_q[k+1];
      win_q[WinLen-1] = b;
    end else begin
      win_q[win_fill] = b;
      win_fill++;
    end
    if (win_fill != WinLen || win_q[0] != StartMark || win_q[WinLen-1] != StopMark) return;
    num = {win_q[4], win_q[3], win_q[2], win_q[1]};
    val = {win_q[8], win_q[7], win_q[6], win_q[5]};
    if (num < ParamCount) begin
      r.action = ACT_PARAM;
      r.target = num[3:0];
    end else if (num >= SpecialLow) begin
      r.action = ACT_SPECIAL;
      r.target = 4'(~num);  // -1 -> 0, -2 -> 1, -3 -> 2
      if (r.target == SPC_MODE && val != spc_store[SPC_MODE]) begin
        if (val == 32'd1) mode_q = MODE_RECORD;
        else if (val == 32'd0) mode_q = MODE_REC_TX;
      end
      spc_store[r.target] = val;
    end else begin
      r.action = ACT_IGNORE;
      r.target = 4'd0;
    end
    r.word = val;
    r.mode = mode_q;
    for (int k = 0; k < WinLen; k++) win_q[k] = 8'd0;
    win_fill = 0;
    frames_due.push_back(r);
    frames_made++;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, rx_gap_max);
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk); while (!rx_bus.ready);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) send_byte(w[8*k +: 8]);
  endtask

  task automatic send_frame(input logic [31:0] num, input logic [31:0] val);
    send_byte(StartMark);
    send_word(num);
    send_word(val);
    send_byte(StopMark);
  endtask

  // result side: random stall, then take one transfer and compare
  initial begin
    int         stall;
    frame_res_t want;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, res_gap_max);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
      frames_seen++;
      if (frames_due.size() == 0) begin
        if (fails < 10) $display("%0t: result with none pending: act=%0d idx=%0d val=%h mode=%0d",
                                 $time, res_bus.action, res_bus.target_index,
                                 res_bus.word_value, res_bus.send_mode);
        fails++;
      end else begin
        want = frames_due.pop_front();
        if (res_bus.action !== want.action || res_bus.target_index !== want.target ||
            res_bus.word_value !== want.word || res_bus.send_mode !== want.mode) begin
          if (fails < 10) begin
            $display("%0t: result mismatch", $time);
            $display("  act exp %0d got %0d, idx exp %0d got %0d", want.action,
                     res_bus.action, want.target, res_bus.target_index);
            $display("  val exp %h got %h, mode exp %0d got %0d", want.word,
                     res_bus.word_value, want.mode, res_bus.send_mode);
          end
          fails++;
        end
      end
    end
  end

  task automatic test_param_extremes();
    send_frame(32'd0, 32'h0000_0000);
    send_frame(32'd15, 32'hFFFF_FFFF);
    send_frame(32'd9, 32'hA5C3_0F81);
  endtask

  task automatic test_special_and_mode();
    send_frame(32'hFFFF_FFFF, 32'd1);    // -1: no mode effect
    send_frame(32'hFFFF_FFFE, 32'd0);    // -2
    send_frame(32'hFFFF_FFFD, 32'd1);    // -3 changed to 1: record
    send_frame(32'hFFFF_FFFD, 32'd1);    // same word: mode kept
    send_frame(32'hFFFF_FFFD, 32'd0);    // record-transmit
    send_frame(32'hFFFF_FFFD, 32'h55);   // other word: mode kept
    send_frame(32'hFFFF_FFFD, 32'd1);
  endtask

  task automatic test_out_of_range();
    send_frame(32'd16, 32'h1234_5678);
    send_frame(32'hFFFF_FFFC, 32'd1);    // -4
    send_frame(32'h7FFF_FFFF, 32'd0);
    send_frame(32'h8000_0000, 32'd1);
  endtask

  task automatic test_detection_edges();
    // stop only eight bytes after start: no frame until the window slides
    send_byte(StartMark);
    for (int k = 0; k < 7; k++) send_byte(8'h00);
    send_byte(StopMark);
    send_byte(StopMark);
    // leading junk then a full frame through a sliding window
    send_byte(8'hFF);
    send_byte(StopMark);
    send_frame(32'd3, 32'h0807_0807);
    // ignored frame with a start mark in its payload; the window must not reuse it
    send_frame(32'hFFFF_FFF0, 32'h0000_0007);
    for (int k = 0; k < 4; k++) send_byte(8'h11);
    send_byte(StopMark);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       send_byte(StartMark);
        1:       send_byte(StopMark);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  task automatic send_random_frame();
    logic [31:0] num;
    logic [31:0] val;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: num = $urandom_range(0, ParamCount - 1);
      4, 5, 6:    num = 32'hFFFF_FFFF - $urandom_range(0, SpecialCount - 1);
      7: begin
        case ($urandom_range(0, 3))
          0:       num = ParamCount;
          1:       num = 32'hFFFF_FFFC;
          2:       num = 32'h8000_0000;
          default: num = 32'h7FFF_FFFF;
        endcase
      end
      default:    num = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       val = 32'd0;
      1:       val = 32'd1;
      2:       val = 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
    send_frame(num, val);
  endtask

  task automatic send_broken_frame();
    int cut;
    cut = $urandom_range(1, 9);
    send_byte(StartMark);
    for (int k = 1; k < cut; k++) send_byte(8'($urandom));
    if ($urandom_range(0, 1)) send_byte(8'($urandom_range(9, 255)));
  endtask

  task automatic test_random_traffic(input int n_bytes, input int min_frames);
    int goal;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal || frames_made < min_frames) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: send_random_frame();
        7:                   send_broken_frame();
        default:             send_noise();
      endcase
    end
  endtask

  task automatic test_back_to_back();
    rx_gap_max  = 0;
    res_gap_max = 0;
    repeat (8) send_random_frame();
    send_noise();
    repeat (4) send_random_frame();
    rx_gap_max  = 3;
    res_gap_max = 3;
  endtask

  initial begin
    int waited;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'd0;
    res_bus.ready  = 1'b0;
    rst_n          = 1'b0;
    fails = 0;
    bytes_sent = 0;
    frames_made = 0;
    frames_seen = 0;
    rx_gap_max  = 3;
    res_gap_max = 3;
    for (int k = 0; k < WinLen; k++) win_q[k] = 8'd0;
    win_fill = 0;
    for (int k = 0; k < SpecialCount; k++) spc_store[k] = 32'd0;
    mode_q = MODE_LIVE;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_param_extremes();
    test_special_and_mode();
    test_out_of_range();
    test_detection_edges();
    test_back_to_back();
    test_random_traffic(800, 60);
    rx_bus.valid <= 1'b0;

    waited = 0;
    while (frames_due.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (frames_due.size() != 0) begin
      $display("%0d expected results never arrived", frames_due.size());
      fails += frames_due.size();
    end

    $display("Sent %0d bytes forming %0d frames; %0d results checked, %0d errors.",
             bytes_sent, frames_made, frames_seen, fails);
    $display("Covered parameter, special, mode-switch and out-of-range frames, noise.");
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
